// File: rtl/core/swm_pkg.sv
`default_nettype none

package swm_pkg;

    localparam int SAMPLE_W          = 32;
    localparam int START_W           = 10;
    localparam int CFG_W             = 8;
    localparam int DEF_MAX_WIDTH     = 128;
    localparam int DEF_MAX_FRAME     = 1024;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 8'd103;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_end;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] window_max;
        logic [START_W-1:0]         window_start;
        logic                       last_of_frame;
    } out_t;

    function automatic logic signed [SAMPLE_W-1:0] smax(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/swm_cell.sv
`default_nettype none

// One stage of the max chain: holds the max of the latest (position+1) samples.
module swm_cell
    import swm_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic signed [SAMPLE_W-1:0] x,
    input  wire logic signed [SAMPLE_W-1:0] prev,
    output logic signed [SAMPLE_W-1:0]      m
);

    logic signed [SAMPLE_W-1:0] m_reg;
    logic signed [SAMPLE_W-1:0] m_next;

    assign m_next = smax(prev, x);
    assign m      = m_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg <= m_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/sliding_window_max_filter.sv
`default_nettype none

// Channel   Dir  Handshake              Payload
// in        in   in_valid / in_ready    in_data  (in_t: sample, frame_end)
// out       out  out_valid / out_ready  out_data (out_t: window_max, window_start,
//                                                 last_of_frame)
// cfg       in   cfg_valid / cfg_ready  cfg_data (window_width)
//
// One sample per cycle while in_ready is high; full-window results are registered.
// Throughput is set by the chain of MAX_WIDTH-1 compare cells, each one
// compare deep, plus one width-selected tap and compare into the output register.
// Reset clears frame count, output valid and sets window_width to 103.
// in_ready is low only while a result is held and out_ready is low.
module sliding_window_max_filter
    import swm_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_FRAME = DEF_MAX_FRAME
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire in_t              in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output out_t                  out_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int CW   = $clog2(MAX_FRAME + 1);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int IW   = $clog2(MAX_WIDTH);
    localparam int EW   = (WW > CFG_W) ? WW : CFG_W;
    localparam int CMPW = (CW > WW) ? CW : WW;
    localparam int NC   = MAX_WIDTH - 1;

    logic [CFG_W-1:0] width_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             out_valid_reg;
    out_t             out_data_reg;

    logic             in_xfer;
    logic [EW-1:0]    w_ext;
    logic [WW-1:0]    w_eff;
    logic [CW:0]      count_inc;
    logic [CW-1:0]    count_sat;
    logic             produce;
    logic [START_W-1:0] start_diff;
    logic [IW-1:0]    tap_idx;
    logic signed [SAMPLE_W-1:0] chain [NC];
    logic signed [SAMPLE_W-1:0] win_max;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Chain of running maxima: cell j holds max of the latest j+1 samples.
    for (genvar j = 0; j < NC; j++)
    begin : g_cell
        swm_cell u_cell (
            .clk  (clk),
            .en   (in_xfer),
            .x    (in_data.sample),
            .prev ((j == 0) ? in_data.sample : chain[(j == 0) ? 0 : j - 1]),
            .m    (chain[j])
        );
    end

    always_comb
    begin
        w_ext = EW'(width_reg);
        if (w_ext == '0)
        begin
            w_ext = EW'(1);
        end
        else if (w_ext > EW'(MAX_WIDTH))
        begin
            w_ext = EW'(MAX_WIDTH);
        end
        w_eff = WW'(w_ext);

        count_inc = {1'b0, count_reg} + (CW + 1)'(1);
        if (count_inc > (CW + 1)'(MAX_FRAME))
        begin
            count_sat = CW'(MAX_FRAME);
        end
        else
        begin
            count_sat = count_inc[CW-1:0];
        end

        produce    = CMPW'(count_sat) >= CMPW'(w_eff);
        // start index wraps at the field width
        start_diff = START_W'(count_sat) - START_W'(w_eff);

        tap_idx = IW'(w_eff - WW'(2));
        if (w_eff == WW'(1))
        begin
            win_max = in_data.sample;
        end
        else
        begin
            win_max = smax(chain[tap_idx], in_data.sample);
        end

        count_next = in_data.frame_end ? '0 : count_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                width_reg <= cfg_data;
            end
            if (in_xfer)
            begin
                count_reg     <= count_next;
                out_valid_reg <= produce;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_data_reg.window_max    <= win_max;
            out_data_reg.window_start  <= start_diff;
            out_data_reg.last_of_frame <= in_data.frame_end;
        end
    end

endmodule

`default_nettype wire
